/* src/aod_pkg.sv */
// Package for the audio onset detector: sequencer states, register indexes,
// reset values and Q2.14 constants. No dependencies.
package aod_pkg;

   localparam int LEVEL_W = 16;
   localparam int ENV_W = 15;
   localparam int TIME_W = 32;
   localparam int DELTA_W = 17;
   localparam int CSR_IDX_W = 2;
   localparam int PROD_W = ENV_W + LEVEL_W;
   localparam int DIV_CNT_W = 5;

   localparam logic [ENV_W-1:0] Q_ONE = ENV_W'(16384);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PROD_W - 1);

   localparam logic [LEVEL_W-1:0] FLOOR_RESET = LEVEL_W'(328);
   localparam logic [LEVEL_W-1:0] RISE_RESET = LEVEL_W'(1311);
   localparam logic [LEVEL_W-1:0] DEBOUNCE_RESET = LEVEL_W'(80);
   localparam logic [LEVEL_W-1:0] RELEASE_RESET = LEVEL_W'(120);

   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RISE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE = 2'd3;

   localparam logic [1:0] CONF_LOW = 2'd0;
   localparam logic [1:0] CONF_CLIPPED = 2'd1;
   localparam logic [1:0] CONF_TRUSTED = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_WRITE
   } state_type;

endpackage

/* src/audio_onset_detector.sv */
// Audio onset detector: envelope release through a multiply and a
// bit-serial divider, onset gating and result register. Uses aod_pkg.
//
//  channel | direction | handshake               | payload
//  req     | in        | req_valid / req_stall   | rms, peak, time of one frame
//  rsp     | out       | rsp_valid / rsp_stall   | ok, onset, attack, envelope, ...
//  csr     | in        | csr_write               | csr_index, csr_wdata
//
// A frame with RMS passes accept, multiply, divide (partial decay only) and write;
// without RMS it goes straight to write. req_stall is high from accept until the
// result is loaded into the output register; a stalled result holds there while the
// next frame is accepted, and the next result waits in the write state. Reset is
// synchronous; frame, divider and result data are not reset, the rest is cleared.
module audio_onset_detector (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_rms_valid,
   input  logic [aod_pkg::LEVEL_W-1:0]       req_rms_level,
   input  logic                              req_peak_valid,
   input  logic [aod_pkg::LEVEL_W-1:0]       req_peak_level,
   input  logic [aod_pkg::TIME_W-1:0]        req_time_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_detector_ok,
   output logic                              rsp_onset_flag,
   output logic [aod_pkg::ENV_W-1:0]         rsp_attack_value,
   output logic [aod_pkg::ENV_W-1:0]         rsp_envelope,
   output logic [aod_pkg::LEVEL_W-1:0]       rsp_rms_echo,
   output logic signed [aod_pkg::DELTA_W-1:0] rsp_rise_delta,
   output logic [1:0]                        rsp_confidence_code,
   input  logic                              csr_write,
   input  logic [aod_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [aod_pkg::LEVEL_W-1:0]       csr_wdata
);
   import aod_pkg::*;

   // configuration
   logic [LEVEL_W-1:0] floor_ff, floor_in;
   logic [LEVEL_W-1:0] rise_ff, rise_in;
   logic [LEVEL_W-1:0] debounce_ff, debounce_in;
   logic [LEVEL_W-1:0] release_ff, release_in;

   // detector state
   logic [ENV_W-1:0]   env_ff, env_in;
   logic [LEVEL_W-1:0] prev_rms_ff, prev_rms_in;
   logic [TIME_W-1:0]  prev_time_ff, prev_time_in;
   logic               have_prev_ff, have_prev_in;
   logic [TIME_W-1:0]  last_onset_ff, last_onset_in;
   logic               onset_seen_ff, onset_seen_in;

   // latched frame
   logic               f_rms_valid_ff, f_rms_valid_in;
   logic [LEVEL_W-1:0] f_rms_ff, f_rms_in;
   logic               f_peak_valid_ff, f_peak_valid_in;
   logic [LEVEL_W-1:0] f_peak_ff, f_peak_in;
   logic [TIME_W-1:0]  f_time_ff, f_time_in;

   // sequencer and divider
   state_type            state_ff, state_in;
   logic [ENV_W-1:0]     env_dec_ff, env_dec_in;
   logic [PROD_W-1:0]    div_q_ff, div_q_in;
   logic [LEVEL_W-1:0]   div_rem_ff, div_rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   // result register
   logic               out_valid_ff, out_valid_in;
   logic               out_ok_ff, out_ok_in;
   logic               out_onset_ff, out_onset_in;
   logic [ENV_W-1:0]   out_attack_ff, out_attack_in;
   logic [ENV_W-1:0]   out_env_ff, out_env_in;
   logic [LEVEL_W-1:0] out_rms_ff, out_rms_in;
   logic [DELTA_W-1:0] out_delta_ff, out_delta_in;
   logic [1:0]         out_conf_ff, out_conf_in;

   logic req_take;
   logic out_free;
   logic commit;

   // decay decision
   logic [TIME_W-1:0]  elapsed;
   logic               no_decay;
   logic               full_decay;
   logic [LEVEL_W-1:0] remain;
   logic [PROD_W-1:0]  product;

   // divider step
   logic [LEVEL_W:0]   rem_shift;
   logic               rem_ge;
   logic [LEVEL_W:0]   rem_sub;

   // gating
   logic [DELTA_W-1:0] delta;
   logic               trusted;
   logic               clipped;
   logic [TIME_W:0]    since_onset;
   logic               debounce_active;
   logic               onset;
   logic [ENV_W-1:0]   attack;
   logic [1:0]         conf;

   assign req_take = req_valid && !req_stall;
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      elapsed = '0;
      if (have_prev_ff && (f_time_ff > prev_time_ff)) begin
         elapsed = f_time_ff - prev_time_ff;
      end
      no_decay = (release_ff == '0) || (elapsed == '0);
      full_decay = elapsed >= {{(TIME_W-LEVEL_W){1'b0}}, release_ff};
      remain = release_ff - elapsed[LEVEL_W-1:0];
      product = PROD_W'(env_ff) * PROD_W'(remain);
   end

   always_comb begin
      rem_shift = {div_rem_ff, div_q_ff[PROD_W-1]};
      rem_ge = rem_shift >= {1'b0, release_ff};
      rem_sub = rem_shift - {1'b0, release_ff};
   end

   always_comb begin
      delta = '0;
      if (have_prev_ff) begin
         delta = {1'b0, f_rms_ff} - {1'b0, prev_rms_ff};
      end
      trusted = f_rms_ff >= floor_ff;
      clipped = f_peak_valid_ff && (f_peak_ff > {1'b0, Q_ONE});
      since_onset = {1'b0, f_time_ff} - {1'b0, last_onset_ff};
      debounce_active = onset_seen_ff &&
         ($signed(since_onset) < $signed({{(TIME_W+1-LEVEL_W){1'b0}}, debounce_ff}));
      onset = trusted && ($signed(delta) >= $signed({1'b0, rise_ff})) && !debounce_active;
      if ($signed(delta) > $signed({{(DELTA_W-ENV_W){1'b0}}, Q_ONE})) begin
         attack = Q_ONE;
      end else begin
         attack = delta[ENV_W-1:0];
      end
      if (!trusted) begin
         conf = CONF_LOW;
      end else if (clipped) begin
         conf = CONF_CLIPPED;
      end else begin
         conf = CONF_TRUSTED;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = req_rms_valid ? ST_MUL : ST_WRITE;
            end
         end
         ST_MUL: begin
            state_in = (no_decay || full_decay) ? ST_WRITE : ST_DIV;
         end
         ST_DIV: begin
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      commit = 1'b0;
      case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_MUL:   req_stall = 1'b1;
         ST_DIV:   req_stall = 1'b1;
         ST_WRITE: commit = out_free;
         default:  req_stall = 1'b1;
      endcase
   end

   // datapath next values
   always_comb begin
      floor_in = floor_ff;
      rise_in = rise_ff;
      debounce_in = debounce_ff;
      release_in = release_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_FLOOR:    floor_in = csr_wdata;
            CSR_RISE:     rise_in = csr_wdata;
            CSR_DEBOUNCE: debounce_in = csr_wdata;
            CSR_RELEASE:  release_in = csr_wdata;
            default:      floor_in = floor_ff;
         endcase
      end

      f_rms_valid_in = f_rms_valid_ff;
      f_rms_in = f_rms_ff;
      f_peak_valid_in = f_peak_valid_ff;
      f_peak_in = f_peak_ff;
      f_time_in = f_time_ff;
      if (req_take) begin
         f_rms_valid_in = req_rms_valid;
         f_rms_in = req_rms_level;
         f_peak_valid_in = req_peak_valid;
         f_peak_in = req_peak_level;
         f_time_in = req_time_ms;
      end

      env_dec_in = env_dec_ff;
      div_q_in = div_q_ff;
      div_rem_in = div_rem_ff;
      div_cnt_in = div_cnt_ff;
      if (state_ff == ST_MUL) begin
         if (no_decay) begin
            env_dec_in = env_ff;
         end else begin
            env_dec_in = '0;
         end
         div_q_in = product;
         div_rem_in = '0;
         div_cnt_in = '0;
      end else if (state_ff == ST_DIV) begin
         // retire one quotient bit
         div_q_in = {div_q_ff[PROD_W-2:0], rem_ge};
         div_rem_in = rem_ge ? rem_sub[LEVEL_W-1:0] : rem_shift[LEVEL_W-1:0];
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         if (div_cnt_ff == DIV_LAST) begin
            env_dec_in = div_q_in[ENV_W-1:0];
         end
      end

      env_in = env_ff;
      prev_rms_in = prev_rms_ff;
      prev_time_in = prev_time_ff;
      have_prev_in = have_prev_ff;
      last_onset_in = last_onset_ff;
      onset_seen_in = onset_seen_ff;

      out_ok_in = out_ok_ff;
      out_onset_in = out_onset_ff;
      out_attack_in = out_attack_ff;
      out_env_in = out_env_ff;
      out_rms_in = out_rms_ff;
      out_delta_in = out_delta_ff;
      out_conf_in = out_conf_ff;

      if (commit) begin
         if (f_rms_valid_ff) begin
            env_in = onset ? attack : env_dec_ff;
            prev_rms_in = f_rms_ff;
            prev_time_in = f_time_ff;
            have_prev_in = 1'b1;
            if (onset) begin
               last_onset_in = f_time_ff;
               onset_seen_in = 1'b1;
            end
            out_ok_in = 1'b1;
            out_onset_in = onset;
            out_attack_in = onset ? attack : '0;
            out_env_in = onset ? attack : env_dec_ff;
            out_rms_in = f_rms_ff;
            out_delta_in = delta;
            out_conf_in = conf;
         end else begin
            // missing RMS: report held envelope, leave detector state untouched
            out_ok_in = 1'b0;
            out_onset_in = 1'b0;
            out_attack_in = '0;
            out_env_in = env_ff;
            out_rms_in = '0;
            out_delta_in = '0;
            out_conf_in = CONF_LOW;
         end
      end

      if (commit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= FLOOR_RESET;
         rise_ff <= RISE_RESET;
         debounce_ff <= DEBOUNCE_RESET;
         release_ff <= RELEASE_RESET;
         env_ff <= '0;
         prev_rms_ff <= '0;
         prev_time_ff <= '0;
         have_prev_ff <= 1'b0;
         last_onset_ff <= '0;
         onset_seen_ff <= 1'b0;
         state_ff <= ST_IDLE;
         div_cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         floor_ff <= floor_in;
         rise_ff <= rise_in;
         debounce_ff <= debounce_in;
         release_ff <= release_in;
         env_ff <= env_in;
         prev_rms_ff <= prev_rms_in;
         prev_time_ff <= prev_time_in;
         have_prev_ff <= have_prev_in;
         last_onset_ff <= last_onset_in;
         onset_seen_ff <= onset_seen_in;
         state_ff <= state_in;
         div_cnt_ff <= div_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      f_rms_valid_ff <= f_rms_valid_in;
      f_rms_ff <= f_rms_in;
      f_peak_valid_ff <= f_peak_valid_in;
      f_peak_ff <= f_peak_in;
      f_time_ff <= f_time_in;
      env_dec_ff <= env_dec_in;
      div_q_ff <= div_q_in;
      div_rem_ff <= div_rem_in;
      out_ok_ff <= out_ok_in;
      out_onset_ff <= out_onset_in;
      out_attack_ff <= out_attack_in;
      out_env_ff <= out_env_in;
      out_rms_ff <= out_rms_in;
      out_delta_ff <= out_delta_in;
      out_conf_ff <= out_conf_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_detector_ok = out_ok_ff;
   assign rsp_onset_flag = out_onset_ff;
   assign rsp_attack_value = out_attack_ff;
   assign rsp_envelope = out_env_ff;
   assign rsp_rms_echo = out_rms_ff;
   assign rsp_rise_delta = $signed(out_delta_ff);
   assign rsp_confidence_code = out_conf_ff;

`ifndef NO_ASSERTIONS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_MUL || state_ff == ST_WRITE))
      else $error("accepted frame did not start the sequencer");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_cnt_ff <= DIV_LAST))
      else $error("divider ran past its last bit");

   a_env_range: assert property (@(posedge clock) disable iff (reset)
      (env_ff <= Q_ONE) && (!out_valid_ff || (out_env_ff <= Q_ONE && out_attack_ff <= Q_ONE)))
      else $error("envelope or attack above 1.0");

   a_onset_trusted: assert property (@(posedge clock) disable iff (reset)
      (commit && out_free) |=> (!out_onset_ff || (out_ok_ff &&
         (out_conf_ff == CONF_CLIPPED || out_conf_ff == CONF_TRUSTED))))
      else $error("onset reported on an untrusted frame");
`endif

endmodule
